// ===== rtl/slx_pkg.sv =====
// slx_pkg: shared types, token and error codes, and character helpers for the
// script lexer. No dependencies.
`timescale 1ns / 1ps

package slx_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_EQ     = 3'd4,
        MODE_BANG   = 3'd5
    } t_scan_mode;

    typedef logic [4:0] t_kind;
    typedef logic [1:0] t_err;
    typedef logic [7:0] t_char;

    // push count from the lexer core into the result queue
    typedef struct packed {
        logic [1:0] count;
    } t_push;

    localparam t_kind KIND_ID      = 5'd0;
    localparam t_kind KIND_NUM     = 5'd1;
    localparam t_kind KIND_STR     = 5'd2;
    localparam t_kind KIND_LPAREN  = 5'd3;
    localparam t_kind KIND_RPAREN  = 5'd4;
    localparam t_kind KIND_COMMA   = 5'd5;
    localparam t_kind KIND_EQUALS  = 5'd6;
    localparam t_kind KIND_PLUS    = 5'd7;
    localparam t_kind KIND_MINUS   = 5'd8;
    localparam t_kind KIND_STAR    = 5'd9;
    localparam t_kind KIND_SLASH   = 5'd10;
    localparam t_kind KIND_LT      = 5'd11;
    localparam t_kind KIND_GT      = 5'd12;
    localparam t_kind KIND_EE      = 5'd13;
    localparam t_kind KIND_NE      = 5'd14;
    localparam t_kind KIND_LBRACE  = 5'd15;
    localparam t_kind KIND_RBRACE  = 5'd16;
    localparam t_kind KIND_KW_IF   = 5'd17;
    localparam t_kind KIND_KW_ELSE = 5'd18;
    localparam t_kind KIND_KW_WHILE = 5'd19;
    localparam t_kind KIND_KW_IN   = 5'd20;
    localparam t_kind KIND_KW_THAT = 5'd21;
    localparam t_kind KIND_KW_CASE = 5'd22;
    localparam t_kind KIND_END     = 5'd23;
    localparam t_kind KIND_NONE    = 5'd31;

    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_UNKNOWN  = 2'd1;
    localparam t_err ERR_BANG     = 2'd2;
    localparam t_err ERR_UNCLOSED = 2'd3;

    // first five bytes of a keyword, byte i at bits 8i
    localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
    localparam logic [39:0] KW_ELSE  = 40'h00_6573_6C65;
    localparam logic [39:0] KW_WHILE = 40'h65_6C69_6877;
    localparam logic [39:0] KW_IN    = 40'h00_0000_6E69;
    localparam logic [39:0] KW_THAT  = 40'h00_7461_6874;
    localparam logic [39:0] KW_CASE  = 40'h00_6573_6163;

    localparam t_char CH_LF     = 8'h0A;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_VT     = 8'h0B;
    localparam t_char CH_FF     = 8'h0C;
    localparam t_char CH_CR     = 8'h0D;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_QUOTE  = 8'h22;
    localparam t_char CH_BANG   = 8'h21;
    localparam t_char CH_EQUALS = 8'h3D;
    localparam t_char CH_UNDER  = 8'h5F;
    localparam t_char CH_DOT    = 8'h2E;

    localparam int FIFO_DEPTH = 8;

    function automatic logic is_alpha(input t_char c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input t_char c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_word(input t_char c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic logic is_blank(input t_char c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic t_kind single_kind(input t_char c);
        t_kind k;
        case (c)
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h2C:   k = KIND_COMMA;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/slx_core.sv =====
// slx_core: lexer state (mode, position, pending token) and result generation
// for one registered byte. Depends on slx_pkg.
`timescale 1ns / 1ps

module slx_core #(
    parameter int POSITION_WIDTH = 16,
    parameter int LENGTH_WIDTH   = 12,
    parameter int RES_WIDTH      = 5 + 2 + 2 * POSITION_WIDTH + LENGTH_WIDTH + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  slx_pkg::t_char       i_char,
    input  logic                 i_eos,
    output slx_pkg::t_push       o_push,
    output logic [RES_WIDTH-1:0] o_res [3]
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
    localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
    localparam logic [LENGTH_WIDTH-1:0]   LEN_FIVE = LENGTH_WIDTH'(5);

    slx_pkg::t_scan_mode       r_mode, n_mode;
    logic [POSITION_WIDTH-1:0] r_line, n_line;
    logic [POSITION_WIDTH-1:0] r_col, n_col;
    logic [POSITION_WIDTH-1:0] r_sline, n_sline;
    logic [POSITION_WIDTH-1:0] r_scol, n_scol;
    logic [LENGTH_WIDTH-1:0]   r_len, n_len;
    logic [39:0]               r_kp, n_kp;
    logic                      r_halt, n_halt;

    logic [RES_WIDTH-1:0] res [3];
    logic [1:0]           cnt;
    logic                 consumed;
    slx_pkg::t_kind       sk;

    function automatic logic [POSITION_WIDTH-1:0] pos_inc(input logic [POSITION_WIDTH-1:0] p);
        return (p == POS_MAX) ? p : p + POS_ONE;
    endfunction

    function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] l);
        return (l == LEN_MAX) ? l : l + LENGTH_WIDTH'(1);
    endfunction

    function automatic logic [RES_WIDTH-1:0] pack_res(
        input slx_pkg::t_kind            kind,
        input slx_pkg::t_err             err,
        input logic [POSITION_WIDTH-1:0] ln,
        input logic [POSITION_WIDTH-1:0] cl,
        input logic [LENGTH_WIDTH-1:0]   len
    );
        return {kind, err, ln, cl, len, 1'b0};
    endfunction

    function automatic slx_pkg::t_kind ident_kind(
        input logic [LENGTH_WIDTH-1:0] len,
        input logic [39:0]             kp
    );
        slx_pkg::t_kind k;
        k = slx_pkg::KIND_ID;
        if (len <= LEN_FIVE) begin
            if (kp == slx_pkg::KW_IF)         k = slx_pkg::KIND_KW_IF;
            else if (kp == slx_pkg::KW_ELSE)  k = slx_pkg::KIND_KW_ELSE;
            else if (kp == slx_pkg::KW_WHILE) k = slx_pkg::KIND_KW_WHILE;
            else if (kp == slx_pkg::KW_IN)    k = slx_pkg::KIND_KW_IN;
            else if (kp == slx_pkg::KW_THAT)  k = slx_pkg::KIND_KW_THAT;
            else if (kp == slx_pkg::KW_CASE)  k = slx_pkg::KIND_KW_CASE;
        end
        return k;
    endfunction

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_sline  = r_sline;
        n_scol   = r_scol;
        n_len    = r_len;
        n_kp     = r_kp;
        n_halt   = r_halt;
        cnt      = 2'd0;
        consumed = 1'b0;
        sk       = slx_pkg::single_kind(i_char);
        res[0]   = '0;
        res[1]   = '0;
        res[2]   = '0;

        if (!r_halt) begin
            // pending token
            case (r_mode)
                slx_pkg::MODE_STRING: begin
                    consumed = 1'b1;
                    if (i_char == slx_pkg::CH_QUOTE) begin
                        n_col = pos_inc(n_col);
                        res[cnt] = pack_res(slx_pkg::KIND_STR, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, n_len);
                        cnt = cnt + 2'd1;
                        n_mode = slx_pkg::MODE_IDLE;
                    end else begin
                        if (i_char == slx_pkg::CH_LF) begin
                            n_line = pos_inc(n_line);
                            n_col  = POS_ONE;
                        end else begin
                            n_col = pos_inc(n_col);
                        end
                        n_len = len_inc(n_len);
                    end
                end
                slx_pkg::MODE_IDENT: begin
                    if (slx_pkg::is_word(i_char)) begin
                        if (n_len < LEN_FIVE) n_kp[8 * n_len[2:0] +: 8] = i_char;
                        n_len = len_inc(n_len);
                        n_col = pos_inc(n_col);
                        consumed = 1'b1;
                    end else begin
                        res[cnt] = pack_res(ident_kind(n_len, n_kp), slx_pkg::ERR_NONE,
                                            n_sline, n_scol, n_len);
                        cnt = cnt + 2'd1;
                        n_mode = slx_pkg::MODE_IDLE;
                    end
                end
                slx_pkg::MODE_NUMBER: begin
                    if (slx_pkg::is_digit(i_char) || i_char == slx_pkg::CH_DOT) begin
                        n_len = len_inc(n_len);
                        n_col = pos_inc(n_col);
                        consumed = 1'b1;
                    end else begin
                        res[cnt] = pack_res(slx_pkg::KIND_NUM, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, n_len);
                        cnt = cnt + 2'd1;
                        n_mode = slx_pkg::MODE_IDLE;
                    end
                end
                slx_pkg::MODE_EQ: begin
                    if (i_char == slx_pkg::CH_EQUALS) begin
                        n_col = pos_inc(n_col);
                        res[cnt] = pack_res(slx_pkg::KIND_EE, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, LENGTH_WIDTH'(2));
                        consumed = 1'b1;
                    end else begin
                        res[cnt] = pack_res(slx_pkg::KIND_EQUALS, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, LENGTH_WIDTH'(1));
                    end
                    cnt = cnt + 2'd1;
                    n_mode = slx_pkg::MODE_IDLE;
                end
                slx_pkg::MODE_BANG: begin
                    if (i_char == slx_pkg::CH_EQUALS) begin
                        n_col = pos_inc(n_col);
                        res[cnt] = pack_res(slx_pkg::KIND_NE, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, LENGTH_WIDTH'(2));
                    end else begin
                        res[cnt] = pack_res(slx_pkg::KIND_ID, slx_pkg::ERR_BANG,
                                            n_line, n_col, '0);
                        n_halt = 1'b1;
                    end
                    cnt = cnt + 2'd1;
                    n_mode = slx_pkg::MODE_IDLE;
                    consumed = 1'b1;
                end
                default: begin
                    n_mode = slx_pkg::MODE_IDLE;
                end
            endcase

            // byte not taken by the pending token starts from idle
            if (!consumed && !n_halt) begin
                if (i_char == slx_pkg::CH_LF) begin
                    n_line = pos_inc(n_line);
                    n_col  = POS_ONE;
                end else if (slx_pkg::is_blank(i_char)) begin
                    n_col = pos_inc(n_col);
                end else if (i_char == slx_pkg::CH_QUOTE || slx_pkg::is_word(i_char)
                             || i_char == slx_pkg::CH_EQUALS
                             || i_char == slx_pkg::CH_BANG) begin
                    n_sline = n_line;
                    n_scol  = n_col;
                    n_len   = '0;
                    n_kp    = '0;
                    if (i_char == slx_pkg::CH_QUOTE) begin
                        n_mode = slx_pkg::MODE_STRING;
                    end else if (slx_pkg::is_digit(i_char)) begin
                        n_mode = slx_pkg::MODE_NUMBER;
                        n_len  = LENGTH_WIDTH'(1);
                    end else if (i_char == slx_pkg::CH_EQUALS) begin
                        n_mode = slx_pkg::MODE_EQ;
                    end else if (i_char == slx_pkg::CH_BANG) begin
                        n_mode = slx_pkg::MODE_BANG;
                    end else begin
                        n_mode     = slx_pkg::MODE_IDENT;
                        n_kp[7:0]  = i_char;
                        n_len      = LENGTH_WIDTH'(1);
                    end
                    n_col = pos_inc(n_col);
                end else begin
                    n_col = pos_inc(n_col);
                    if (sk != slx_pkg::KIND_NONE) begin
                        res[cnt] = pack_res(sk, slx_pkg::ERR_NONE, n_line,
                                            n_col - POS_ONE, LENGTH_WIDTH'(1));
                    end else begin
                        res[cnt] = pack_res(slx_pkg::KIND_ID, slx_pkg::ERR_UNKNOWN,
                                            n_line, n_col, '0);
                        n_halt = 1'b1;
                        n_mode = slx_pkg::MODE_IDLE;
                    end
                    cnt = cnt + 2'd1;
                end
            end

            // last byte: flush pending token, then end token
            if (i_eos && !n_halt) begin
                case (n_mode)
                    slx_pkg::MODE_STRING: begin
                        res[cnt] = pack_res(slx_pkg::KIND_ID, slx_pkg::ERR_UNCLOSED,
                                            n_line, n_col, '0);
                        cnt = cnt + 2'd1;
                        n_halt = 1'b1;
                    end
                    slx_pkg::MODE_IDENT: begin
                        res[cnt] = pack_res(ident_kind(n_len, n_kp), slx_pkg::ERR_NONE,
                                            n_sline, n_scol, n_len);
                        cnt = cnt + 2'd1;
                    end
                    slx_pkg::MODE_NUMBER: begin
                        res[cnt] = pack_res(slx_pkg::KIND_NUM, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, n_len);
                        cnt = cnt + 2'd1;
                    end
                    slx_pkg::MODE_EQ: begin
                        res[cnt] = pack_res(slx_pkg::KIND_EQUALS, slx_pkg::ERR_NONE,
                                            n_sline, n_scol, LENGTH_WIDTH'(1));
                        cnt = cnt + 2'd1;
                    end
                    slx_pkg::MODE_BANG: begin
                        res[cnt] = pack_res(slx_pkg::KIND_ID, slx_pkg::ERR_BANG,
                                            n_line, n_col, '0);
                        cnt = cnt + 2'd1;
                        n_halt = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (!n_halt) begin
                    res[cnt] = pack_res(slx_pkg::KIND_END, slx_pkg::ERR_NONE,
                                        n_line, n_col, '0);
                    cnt = cnt + 2'd1;
                end
            end
        end

        if (i_eos) begin
            n_mode  = slx_pkg::MODE_IDLE;
            n_line  = POS_ONE;
            n_col   = POS_ONE;
            n_sline = '0;
            n_scol  = '0;
            n_len   = '0;
            n_kp    = '0;
            n_halt  = 1'b0;
        end

        // mark last result of this byte
        case (cnt)
            2'd1:    res[0][0] = 1'b1;
            2'd2:    res[1][0] = 1'b1;
            2'd3:    res[2][0] = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= slx_pkg::MODE_IDLE;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_sline <= '0;
            r_scol  <= '0;
            r_len   <= '0;
            r_kp    <= '0;
            r_halt  <= 1'b0;
        end else if (i_go) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_len   <= n_len;
            r_kp    <= n_kp;
            r_halt  <= n_halt;
        end
    end

    assign o_push.count = i_go ? cnt : 2'd0;
    assign o_res        = res;

endmodule

// ===== rtl/slx_fifo.sv =====
// slx_fifo: result queue taking up to three results per cycle and giving one
// per output transfer. Depends on slx_pkg.
`timescale 1ns / 1ps

module slx_fifo #(
    parameter int WIDTH = 58
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slx_pkg::t_push   i_push,
    input  logic [WIDTH-1:0] i_data [3],
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_room3,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = slx_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign o_valid = r_cnt != '0;
    assign o_room3 = r_cnt <= CNT_W'(DEPTH - 3);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.count);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (2'(k) < i_push.count) r_mem[r_wr + PTR_W'(k)] <= i_data[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/script_lexer_top.sv =====
// Path: a byte is registered at its input transfer, and its results are written into
// the result queue once that queue has room; the output reads from the queue's storage.
// Throughput: one byte per cycle while bytes cause at most one result; a byte
// causing k results needs k output transfers from the eight-entry result queue,
// and input stalls while that queue has fewer than three free entries.
// Reset: synchronous active low; line and column return to 1, queue empties.
`timescale 1ns / 1ps

module script_lexer_top #(
    parameter int POSITION_WIDTH = 16,
    parameter int LENGTH_WIDTH   = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_char_code,
    input  logic                      i_end_of_source,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [4:0]                o_token_kind,
    output logic [1:0]                o_error_code,
    output logic [POSITION_WIDTH-1:0] o_start_line,
    output logic [POSITION_WIDTH-1:0] o_start_column,
    output logic [LENGTH_WIDTH-1:0]   o_text_length,
    output logic                      o_run_end
);

    localparam int RES_WIDTH = 5 + 2 + 2 * POSITION_WIDTH + LENGTH_WIDTH + 1;

    logic                 r_in_valid;
    slx_pkg::t_char       r_char;
    logic                 r_eos;
    logic                 go;
    logic                 room3;
    slx_pkg::t_push       push;
    logic [RES_WIDTH-1:0] res [3];
    logic [RES_WIDTH-1:0] rd_data;

    assign go         = r_in_valid && room3;
    assign o_in_ready = !r_in_valid || go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_char_code;
            r_eos  <= i_end_of_source;
        end
    end

    slx_core #(
        .POSITION_WIDTH(POSITION_WIDTH),
        .LENGTH_WIDTH  (LENGTH_WIDTH),
        .RES_WIDTH     (RES_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (go),
        .i_char (r_char),
        .i_eos  (r_eos),
        .o_push (push),
        .o_res  (res)
    );

    slx_fifo #(
        .WIDTH(RES_WIDTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (res),
        .i_pop  (i_out_ready),
        .o_valid(o_out_valid),
        .o_room3(room3),
        .o_data (rd_data)
    );

    assign {o_token_kind, o_error_code, o_start_line, o_start_column,
            o_text_length, o_run_end} = rd_data;

endmodule

// ===== rtl/slx_checker.sv =====
// slx_checker: port-level assertions for script_lexer_top, attached by bind.
// Depends on slx_pkg.
`timescale 1ns / 1ps

module slx_checker #(
    parameter int POSITION_WIDTH = 16,
    parameter int LENGTH_WIDTH   = 12
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [4:0]                o_token_kind,
    input logic [1:0]                o_error_code,
    input logic [POSITION_WIDTH-1:0] o_start_line,
    input logic [POSITION_WIDTH-1:0] o_start_column,
    input logic [LENGTH_WIDTH-1:0]   o_text_length,
    input logic                      o_run_end
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_start_line) && $stable(o_start_column)
            && $stable(o_text_length) && $stable(o_run_end))
        else $error("result changed while stalled");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != slx_pkg::ERR_NONE |->
            o_token_kind == slx_pkg::KIND_ID && o_text_length == '0 && o_run_end)
        else $error("malformed error result");

    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == slx_pkg::KIND_END |->
            o_run_end && o_text_length == '0 && o_error_code == slx_pkg::ERR_NONE)
        else $error("malformed end token");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_start_line != '0 && o_start_column != '0)
        else $error("zero position in result");

endmodule

bind script_lexer_top slx_checker #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
) u_slx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_token_kind  (o_token_kind),
    .o_error_code  (o_error_code),
    .o_start_line  (o_start_line),
    .o_start_column(o_start_column),
    .o_text_length (o_text_length),
    .o_run_end     (o_run_end)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for script_lexer_top. It drives source bytes,
// predicts the token stream in the bench, and checks every output transfer.
// Depends on rtl/slx_pkg.sv and rtl/script_lexer_top.sv.
`timescale 1ns / 1ps

module tb_top;

    localparam int PW            = 16;
    localparam int LW            = 12;
    localparam int CLK_PERIOD    = 10;
    localparam int N_DIRECTED    = 25;
    localparam int RANDOM_ITEMS  = 140;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 40;
    localparam logic [PW-1:0] POS_TOP = {PW{1'b1}};
    localparam logic [LW-1:0] LEN_TOP = {LW{1'b1}};

    typedef struct {
        slx_pkg::t_kind kind;
        slx_pkg::t_err  err;
        logic [PW-1:0]  line;
        logic [PW-1:0]  col;
        logic [LW-1:0]  len;
        bit             last;
    } t_token;

    typedef struct {
        slx_pkg::t_char ch;
        bit             eos;
        bit             typed;
        slx_pkg::t_kind kind;
        slx_pkg::t_err  err;
        logic [PW-1:0]  ln;
        logic [PW-1:0]  cl;
        logic [LW-1:0]  n;
    } t_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [7:0]          i_char_code;
    logic                i_end_of_source;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [4:0]          o_token_kind;
    logic [1:0]          o_error_code;
    logic [PW-1:0]       o_start_line;
    logic [PW-1:0]       o_start_column;
    logic [LW-1:0]       o_text_length;
    logic                o_run_end;

    script_lexer_top #(
        .POSITION_WIDTH(PW),
        .LENGTH_WIDTH  (LW)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_char_code    (i_char_code),
        .i_end_of_source(i_end_of_source),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_token_kind   (o_token_kind),
        .o_error_code   (o_error_code),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_text_length  (o_text_length),
        .o_run_end      (o_run_end)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // bench copy of the lexer state
    slx_pkg::t_scan_mode lx_mode;
    logic [PW-1:0] lx_line;
    logic [PW-1:0] lx_col;
    logic [PW-1:0] lx_tline;
    logic [PW-1:0] lx_tcol;
    logic [LW-1:0] lx_len;
    logic [39:0]   lx_prefix;
    bit            lx_halted;

    t_token         byte_toks[$];
    t_token         token_q[$];
    slx_pkg::t_char src_bytes[$];

    string kw_words[6]   = '{"if", "else", "while", "in", "that", "case"};
    string near_words[8] = '{"iff", "whiles", "Else", "els", "thatt", "_case", "in_", "cas"};
    string eq_words[3]   = '{"=", "==", "!="};
    string op_chars      = "(),+-*/<>{}";
    string id_head       = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string id_body       = "abcdefghijwxyzHIJKLMNXYZ_0123456789";
    string num_body      = "0123456789.";

    bit tx_idle_on;
    bit rx_idle_on;
    bit rx_hold;

    int mismatches     = 0;
    int tokens_checked = 0;
    int errors_checked = 0;
    int live_bytes;
    int sources_sent;
    int quiet_cycles   = 0;

    t_token no_want;

    t_row script_rows[N_DIRECTED] = '{
        '{"(",   1'b0, 1'b1, slx_pkg::KIND_LPAREN, slx_pkg::ERR_NONE,    1, 1, 1},
        '{8'hFF, 1'b0, 1'b1, slx_pkg::KIND_ID,     slx_pkg::ERR_UNKNOWN, 1, 3, 0},
        '{"x",   1'b1, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"!",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"a",   1'b0, 1'b1, slx_pkg::KIND_ID,     slx_pkg::ERR_BANG,    1, 2, 0},
        '{8'h00, 1'b1, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"i",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"f",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{slx_pkg::CH_TAB, 1'b0, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{"=",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"=",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"!",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"=",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"=",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{"9",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{".",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{slx_pkg::CH_LF, 1'b0, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{slx_pkg::CH_QUOTE, 1'b0, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{slx_pkg::CH_LF, 1'b0, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{"}",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{slx_pkg::CH_QUOTE, 1'b0, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{"_",   1'b0, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0},
        '{slx_pkg::CH_QUOTE, 1'b1, 1'b0, slx_pkg::KIND_ID, slx_pkg::ERR_NONE, 0, 0, 0},
        '{8'h7F, 1'b1, 1'b1, slx_pkg::KIND_ID,     slx_pkg::ERR_UNKNOWN, 1, 2, 0},
        '{"=",   1'b1, 1'b0, slx_pkg::KIND_ID,     slx_pkg::ERR_NONE,    0, 0, 0}
    };

    // ---------------- token predictor ----------------

    function automatic bit letter(slx_pkg::t_char c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit numeral(slx_pkg::t_char c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(slx_pkg::t_char c);
        return letter(c) || numeral(c) || c == "_";
    endfunction

    function automatic bit blank(slx_pkg::t_char c);
        return c == slx_pkg::CH_SPACE || c == slx_pkg::CH_TAB || c == slx_pkg::CH_VT
            || c == slx_pkg::CH_FF || c == slx_pkg::CH_CR;
    endfunction

    function automatic slx_pkg::t_kind op_kind(slx_pkg::t_char c);
        case (c)
            "(":     return slx_pkg::KIND_LPAREN;
            ")":     return slx_pkg::KIND_RPAREN;
            ",":     return slx_pkg::KIND_COMMA;
            "+":     return slx_pkg::KIND_PLUS;
            "-":     return slx_pkg::KIND_MINUS;
            "*":     return slx_pkg::KIND_STAR;
            "/":     return slx_pkg::KIND_SLASH;
            "<":     return slx_pkg::KIND_LT;
            ">":     return slx_pkg::KIND_GT;
            "{":     return slx_pkg::KIND_LBRACE;
            "}":     return slx_pkg::KIND_RBRACE;
            default: return slx_pkg::KIND_NONE;
        endcase
    endfunction

    function automatic logic [39:0] pack5(string s);
        logic [39:0] v = '0;
        for (int i = 0; i < 5 && i < s.len(); i++) v |= 40'(s[i]) << (8 * i);
        return v;
    endfunction

    function automatic slx_pkg::t_kind word_kind();
        if (lx_len > 5) return slx_pkg::KIND_ID;
        for (int i = 0; i < 6; i++) begin
            if (lx_prefix == pack5(kw_words[i]))
                return slx_pkg::t_kind'(slx_pkg::KIND_KW_IF + i);
        end
        return slx_pkg::KIND_ID;
    endfunction

    function automatic void lx_restart();
        lx_mode   = slx_pkg::MODE_IDLE;
        lx_line   = 1;
        lx_col    = 1;
        lx_tline  = 0;
        lx_tcol   = 0;
        lx_len    = 0;
        lx_prefix = '0;
        lx_halted = 1'b0;
    endfunction

    function automatic void emit_tok(slx_pkg::t_kind k, slx_pkg::t_err e, logic [PW-1:0] ln,
                                     logic [PW-1:0] cl, logic [LW-1:0] n);
        t_token t;
        t.kind = k;
        t.err  = e;
        t.line = ln;
        t.col  = cl;
        t.len  = n;
        t.last = 1'b0;
        byte_toks.insert(byte_toks.size(), t);
    endfunction

    function automatic void step_col();
        if (lx_col != POS_TOP) lx_col++;
    endfunction

    function automatic void step_len();
        if (lx_len != LEN_TOP) lx_len++;
    endfunction

    function automatic void step_line();
        if (lx_line != POS_TOP) lx_line++;
        lx_col = 1;
    endfunction

    function automatic void lx_error(slx_pkg::t_err e);
        emit_tok(slx_pkg::KIND_ID, e, lx_line, lx_col, 0);
        lx_mode   = slx_pkg::MODE_IDLE;
        lx_halted = 1'b1;
    endfunction

    function automatic void open_tok(slx_pkg::t_scan_mode m);
        lx_tline  = lx_line;
        lx_tcol   = lx_col;
        lx_len    = 0;
        lx_prefix = '0;
        lx_mode   = m;
    endfunction

    function automatic void fresh_byte(slx_pkg::t_char c);
        slx_pkg::t_kind k;
        if (c == slx_pkg::CH_LF) begin
            step_line();
        end else if (blank(c)) begin
            step_col();
        end else if (c == slx_pkg::CH_QUOTE) begin
            open_tok(slx_pkg::MODE_STRING);
            step_col();
        end else if (letter(c) || c == "_") begin
            open_tok(slx_pkg::MODE_IDENT);
            lx_prefix = 40'(c);
            lx_len    = 1;
            step_col();
        end else if (numeral(c)) begin
            open_tok(slx_pkg::MODE_NUMBER);
            lx_len = 1;
            step_col();
        end else if (c == "=") begin
            open_tok(slx_pkg::MODE_EQ);
            step_col();
        end else if (c == "!") begin
            open_tok(slx_pkg::MODE_BANG);
            step_col();
        end else begin
            k = op_kind(c);
            step_col();
            if (k != slx_pkg::KIND_NONE)
                emit_tok(k, slx_pkg::ERR_NONE, lx_line, lx_col - 1'b1, 1);
            else lx_error(slx_pkg::ERR_UNKNOWN);
        end
    endfunction

    // tokens caused by one source byte land in byte_toks
    function automatic void lex_byte(slx_pkg::t_char c, bit eos);
        bit used = 1'b0;
        byte_toks.delete();
        if (lx_halted) begin
            if (eos) lx_restart();
            return;
        end
        case (lx_mode)
            slx_pkg::MODE_STRING: begin
                used = 1'b1;
                if (c == slx_pkg::CH_QUOTE) begin
                    step_col();
                    emit_tok(slx_pkg::KIND_STR, slx_pkg::ERR_NONE, lx_tline, lx_tcol, lx_len);
                    lx_mode = slx_pkg::MODE_IDLE;
                end else begin
                    if (c == slx_pkg::CH_LF) step_line();
                    else step_col();
                    step_len();
                end
            end
            slx_pkg::MODE_IDENT: begin
                if (word_char(c)) begin
                    if (lx_len < 5) lx_prefix |= 40'(c) << (8 * lx_len);
                    step_len();
                    step_col();
                    used = 1'b1;
                end else begin
                    emit_tok(word_kind(), slx_pkg::ERR_NONE, lx_tline, lx_tcol, lx_len);
                    lx_mode = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_NUMBER: begin
                if (numeral(c) || c == slx_pkg::CH_DOT) begin
                    step_len();
                    step_col();
                    used = 1'b1;
                end else begin
                    emit_tok(slx_pkg::KIND_NUM, slx_pkg::ERR_NONE, lx_tline, lx_tcol, lx_len);
                    lx_mode = slx_pkg::MODE_IDLE;
                end
            end
            slx_pkg::MODE_EQ: begin
                if (c == "=") begin
                    step_col();
                    emit_tok(slx_pkg::KIND_EE, slx_pkg::ERR_NONE, lx_tline, lx_tcol, 2);
                    used = 1'b1;
                end else begin
                    emit_tok(slx_pkg::KIND_EQUALS, slx_pkg::ERR_NONE, lx_tline, lx_tcol, 1);
                end
                lx_mode = slx_pkg::MODE_IDLE;
            end
            slx_pkg::MODE_BANG: begin
                if (c == "=") begin
                    step_col();
                    emit_tok(slx_pkg::KIND_NE, slx_pkg::ERR_NONE, lx_tline, lx_tcol, 2);
                    lx_mode = slx_pkg::MODE_IDLE;
                end else begin
                    lx_error(slx_pkg::ERR_BANG);
                end
                used = 1'b1;
            end
            default: lx_mode = slx_pkg::MODE_IDLE;
        endcase
        if (!used && !lx_halted) fresh_byte(c);
        if (eos) begin
            if (!lx_halted) begin
                case (lx_mode)
                    slx_pkg::MODE_STRING: lx_error(slx_pkg::ERR_UNCLOSED);
                    slx_pkg::MODE_IDENT:
                        emit_tok(word_kind(), slx_pkg::ERR_NONE, lx_tline, lx_tcol, lx_len);
                    slx_pkg::MODE_NUMBER:
                        emit_tok(slx_pkg::KIND_NUM, slx_pkg::ERR_NONE, lx_tline, lx_tcol,
                                 lx_len);
                    slx_pkg::MODE_EQ:
                        emit_tok(slx_pkg::KIND_EQUALS, slx_pkg::ERR_NONE, lx_tline, lx_tcol,
                                 1);
                    slx_pkg::MODE_BANG:   lx_error(slx_pkg::ERR_BANG);
                    default:     ;
                endcase
                if (!lx_halted)
                    emit_tok(slx_pkg::KIND_END, slx_pkg::ERR_NONE, lx_line, lx_col, 0);
            end
            lx_restart();
        end
        if (byte_toks.size() > 0) byte_toks[$].last = 1'b1;
    endfunction

    // ---------------- random source text ----------------

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic slx_pkg::t_char pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void put_byte(slx_pkg::t_char c);
        src_bytes.insert(src_bytes.size(), c);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic slx_pkg::t_char text_char();
        slx_pkg::t_char c = slx_pkg::t_char'($urandom_range(32, 126));
        return (c == slx_pkg::CH_QUOTE) ? slx_pkg::CH_LF : c;
    endfunction

    function automatic void add_token();
        case ($urandom_range(0, 9))
            0: put_text(kw_words[$urandom_range(0, 5)]);
            1: put_text(near_words[$urandom_range(0, 7)]);
            2, 3: begin
                put_byte(pick_char(id_head));
                repeat ($urandom_range(0, 7)) put_byte(pick_char(id_body));
            end
            4: begin
                put_byte(slx_pkg::t_char'($urandom_range("0", "9")));
                repeat ($urandom_range(0, 5)) put_byte(pick_char(num_body));
            end
            5: begin
                put_byte(slx_pkg::CH_QUOTE);
                repeat ($urandom_range(0, 8)) put_byte(text_char());
                put_byte(slx_pkg::CH_QUOTE);
            end
            6, 7: put_byte(pick_char(op_chars));
            default: put_text(eq_words[$urandom_range(0, 2)]);
        endcase
    endfunction

    function automatic void add_spacing();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: put_byte(slx_pkg::CH_SPACE);
            4:          put_byte(slx_pkg::CH_TAB);
            5:          put_byte(slx_pkg::CH_LF);
            6: begin
                case ($urandom_range(0, 2))
                    0:       put_byte(slx_pkg::CH_VT);
                    1:       put_byte(slx_pkg::CH_FF);
                    default: put_byte(slx_pkg::CH_CR);
                endcase
            end
            default: ;
        endcase
    endfunction

    // mostly well-formed token runs, with some noise and broken endings
    function automatic void compose_source();
        int pick;
        src_bytes.delete();
        repeat ($urandom_range(1, 7)) begin
            add_token();
            add_spacing();
        end
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            src_bytes.insert($urandom_range(0, src_bytes.size()),
                             slx_pkg::t_char'($urandom_range(0, 255)));
        end else if (pick < 5) begin
            put_byte(slx_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) put_byte(text_char());
        end else if (pick == 5) begin
            put_text("!x");
        end else if (pick == 6) begin
            put_text("!");
        end
    endfunction

    // ---------------- sender ----------------

    task automatic send_byte(input slx_pkg::t_char ch, input bit eos, input bit typed,
                             input t_token want);
        int gap;
        i_in_valid      <= 1'b1;
        i_char_code     <= ch;
        i_end_of_source <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (!lx_halted) live_bytes++;
        lex_byte(ch, eos);
        if (typed) begin
            token_q.insert(token_q.size(), want);
        end else begin
            foreach (byte_toks[i]) token_q.insert(token_q.size(), byte_toks[i]);
        end
        @(negedge i_clk);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain_tokens();
        i_in_valid <= 1'b0;
        while (token_q.size() != 0) @(negedge i_clk);
    endtask

    // ---------------- receiver ----------------

    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                i_out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
                stall_left = 0;
            end else if (!rx_idle_on) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                if (stall_left > 0) begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // ---------------- checker ----------------

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_token exp_tok;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (token_q.size() == 0) begin
                flag_mismatch("token with nothing pending, kind", o_token_kind, 0);
            end else begin
                exp_tok = token_q.pop_front();
                tokens_checked++;
                if (exp_tok.err != slx_pkg::ERR_NONE) errors_checked++;
                if (o_token_kind != exp_tok.kind)
                    flag_mismatch("token_kind", o_token_kind, exp_tok.kind);
                if (o_error_code != exp_tok.err)
                    flag_mismatch("error_code", o_error_code, exp_tok.err);
                if (o_start_line != exp_tok.line)
                    flag_mismatch("start_line", o_start_line, exp_tok.line);
                if (o_start_column != exp_tok.col)
                    flag_mismatch("start_column", o_start_column, exp_tok.col);
                if (o_text_length != exp_tok.len)
                    flag_mismatch("text_length", o_text_length, exp_tok.len);
                if (o_run_end != exp_tok.last)
                    flag_mismatch("run_end", o_run_end, exp_tok.last);
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("timeout: no transfer for %0d cycles, %0d tokens pending",
                 QUIET_LIMIT, token_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

    // ---------------- main sequence ----------------

    initial begin : main_seq
        t_token want;
        int     random_start;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_char_code     = '0;
        i_end_of_source = 1'b0;
        i_out_ready     = 1'b0;
        tx_idle_on      = 1'b1;
        rx_idle_on      = 1'b1;
        rx_hold         = 1'b0;
        live_bytes      = 0;
        sources_sent    = 0;
        no_want         = '{slx_pkg::KIND_ID, slx_pkg::ERR_NONE, '0, '0, '0, 1'b0};
        lx_restart();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: errors, lookahead, flush at end, strings across lines
        foreach (script_rows[i]) begin
            want = '{script_rows[i].kind, script_rows[i].err, script_rows[i].ln,
                     script_rows[i].cl, script_rows[i].n, 1'b1};
            send_byte(script_rows[i].ch, script_rows[i].eos, script_rows[i].typed, want);
        end
        drain_tokens();

        // backpressure: output held off while every operator byte is offered
        tx_idle_on = 1'b0;
        rx_hold    = 1'b1;
        repeat (3) begin
            for (int k = 0; k < op_chars.len(); k++)
                send_byte(op_chars[k], 1'b0, 1'b0, no_want);
        end
        send_byte(slx_pkg::CH_SPACE, 1'b1, 1'b0, no_want);
        drain_tokens();

        random_start = live_bytes;
        while (live_bytes - random_start < RANDOM_ITEMS) begin
            tx_idle_on = ($urandom_range(0, 4) != 0);
            rx_idle_on = ($urandom_range(0, 4) != 0);
            compose_source();
            for (int i = 0; i < src_bytes.size(); i++)
                send_byte(src_bytes[i], i == src_bytes.size() - 1, 1'b0, no_want);
            sources_sent++;
            if (sources_sent % 4 == 0) drain_tokens();
        end
        drain_tokens();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("covered %0d live bytes, %0d random sources, %0d tokens checked (%0d errors)",
                 live_bytes, sources_sent, tokens_checked, errors_checked);
        $display("with an output hold-off, random pauses on both sides and drains to empty");
        if (mismatches == 0 && token_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/slx_pkg.sv
rtl/slx_core.sv
rtl/slx_fifo.sv
rtl/script_lexer_top.sv
rtl/slx_checker.sv
test/tb_top.sv
